// ----- design/ip_prefix_filter_rate_limiter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the prefix filter RTL.
// ----------------------------------------------------------------------------
`ifndef IP_PREFIX_FILTER_RATE_LIMITER_MACROS_SVH
`define IP_PREFIX_FILTER_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPFRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ipfrl assertion failed");

// Next-cycle implication, checked outside reset.
`define IPFRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ipfrl assertion failed");

`endif

// ----- design/ipfrl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfrl_pkg
// Types, codes and helper functions of the IPv4 prefix filter.
// ----------------------------------------------------------------------------
package ipfrl_pkg;

	localparam int FULL_LEN = 32;
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam int TIME_W   = 64;
	localparam int CNT_W    = 64;
	localparam int PFX_W    = ADDR_W + LEN_W;
	localparam int RATE_W   = ADDR_W + TIME_W;
	localparam int CTR_W    = 2 * CNT_W;

	typedef enum logic [2:0] {
		OP_PACKET   = 3'd0,
		OP_WR_ALLOW = 3'd1,
		OP_WR_DENY  = 3'd2,
		OP_WR_RATE  = 3'd3,
		OP_RD_SRC   = 3'd4,
		OP_RD_TOT   = 3'd5
	} op_t;

	localparam logic [1:0] CFG_ALLOW_EN = 2'd0;
	localparam logic [1:0] CFG_DENY_EN  = 2'd1;
	localparam logic [1:0] CFG_RATE_EN  = 2'd2;

	// Lengths are saturated to 32 before they are stored.
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = (len > LEN_W'(FULL_LEN)) ? LEN_W'(FULL_LEN) : len;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else begin
			m = {ADDR_W{1'b1}} << (LEN_W'(FULL_LEN) - sat_len(len));
		end
		return m;
	endfunction

endpackage

// ----- design/ip_prefix_filter_rate_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_filter_rate_limiter
// IPv4 allow/deny prefix filter with per-source counters and rate limiting.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) carries one item per operation:
// a packet, a table write, or a counter read. Every item gives exactly one
// result item on the output channel (out_valid/out_stall).
// Packets and source-stat reads scan all tables through their RAMs, one
// entry per cycle, over the longest of SOURCE_ENTRIES, PREFIX_ENTRIES and
// RATE_ENTRIES, then pass through compare, decision and counter update.
// Table writes, total reads and non-IPv4 packets go straight from idle to
// the finish state, which loads the output register. One item is in work
// at a time; the scan over all tables sets the throughput.
// The result sits in an output register; while the receiver stalls, a
// finished item waits there and the next item may already be accepted.
// The configuration channel (cfg_valid/cfg_ready) is always ready; the
// user must write it only while the block is idle, which the block does not enforce.
// Reset clears the enables, all used bits, the counter fill and totals.
// ----------------------------------------------------------------------------
module ip_prefix_filter_rate_limiter #(
	parameter int SOURCE_ENTRIES = 64,
	parameter int PREFIX_ENTRIES = 16,
	parameter int RATE_ENTRIES   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] address,
	input  logic [15:0] frame_bytes,
	input  logic        is_ipv4,
	input  logic [63:0] now_ns,
	input  logic [3:0]  slot,
	input  logic [5:0]  prefix_len,
	input  logic [63:0] interval_ns,
	input  logic        entry_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic        logged,
	output logic [31:0] log_source,
	output logic [15:0] log_bytes,
	output logic        found,
	output logic [63:0] drop_count,
	output logic [63:0] pass_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

`include "ip_prefix_filter_rate_limiter_macros.svh"

	localparam int SCAN_A   = (SOURCE_ENTRIES > PREFIX_ENTRIES) ?
		SOURCE_ENTRIES : PREFIX_ENTRIES;
	localparam int SCAN_LEN = (SCAN_A > RATE_ENTRIES) ? SCAN_A : RATE_ENTRIES;
	localparam int KW  = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
	localparam int SAW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
	localparam int PAW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
	localparam int RAW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
	localparam int FW  = $clog2(SOURCE_ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DECIDE,
		ST_FIN
	} state_t;

	state_t state_q;

	// Latched item.
	ipfrl_pkg::op_t op_q;
	logic [31:0] addr_q;
	logic [15:0] bytes_q;
	logic        ipv4_q;
	logic [63:0] now_q;
	logic [3:0]  slot_q;
	logic [5:0]  plen_q;
	logic [63:0] gap_in_q;
	logic        ent_valid_q;

	logic reg_allow_q, reg_deny_q, reg_rate_q;

	logic [KW-1:0] k_q, k_s1;
	logic          scan_v_s1;
	logic [FW-1:0] fill_q;

	logic                allow_used_q [PREFIX_ENTRIES];
	logic                deny_used_q [PREFIX_ENTRIES];
	logic                rate_used_q [RATE_ENTRIES];
	logic                seen_q [RATE_ENTRIES];

	logic           src_hit_q;
	logic [SAW-1:0] src_idx_q;
	logic           allow_hit_q, deny_hit_q;
	logic           rate_hit_q, rate_seen_q;
	logic [RAW-1:0] rate_idx_q;
	logic [63:0]    rate_gap_q, rate_last_q;
	logic           drop_q;

	logic [63:0] total_drops_q, total_passes_q;

	// RAM ports.
	logic                         tag_we, ctr_we, allow_we, deny_we, rate_we, stamp_we;
	logic [SAW-1:0]               tag_waddr, ctr_waddr;
	logic [31:0]                  tag_rd;
	logic [ipfrl_pkg::CTR_W-1:0]  ctr_wdata, ctr_rd;
	logic [ipfrl_pkg::PFX_W-1:0]  pfx_wdata, allow_rd, deny_rd;
	logic [ipfrl_pkg::RATE_W-1:0] rate_wdata, rate_rd;
	logic [63:0]                  stamp_rd;

	logic fin_go;
	logic out_free;
	logic claim;
	logic is_pkt;
	logic rate_apply, rate_block, pre_drop;
	logic [63:0] diff;
	logic [63:0] new_drops, new_passes;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	assign fin_go    = (state_q == ST_FIN) && out_free;

	assign is_pkt = (op_q == ipfrl_pkg::OP_PACKET) && ipv4_q;
	assign claim  = !src_hit_q && (fill_q < FW'(SOURCE_ENTRIES));

	// Decision terms: allow, then deny, then the interval check.
	assign pre_drop   = (reg_allow_q && !allow_hit_q) || (reg_deny_q && deny_hit_q);
	assign rate_apply = is_pkt && !pre_drop && reg_rate_q && rate_hit_q;
	assign diff       = now_q - rate_last_q;
	assign rate_block = rate_seen_q && (diff < rate_gap_q);

	assign tag_we    = fin_go && is_pkt && claim;
	assign tag_waddr = fill_q[SAW-1:0];
	assign ctr_we    = fin_go && is_pkt && (src_hit_q || claim);
	assign ctr_waddr = src_hit_q ? src_idx_q : fill_q[SAW-1:0];

	always_comb begin
		if (src_hit_q) begin
			new_drops  = ctr_rd[127:64] + (drop_q ? 64'd1 : 64'd0);
			new_passes = ctr_rd[63:0] + (drop_q ? 64'd0 : 64'd1);
		end else begin
			new_drops  = drop_q ? 64'd1 : 64'd0;
			new_passes = drop_q ? 64'd0 : 64'd1;
		end
		ctr_wdata = {new_drops, new_passes};
	end

	assign pfx_wdata  = {addr_q, ipfrl_pkg::sat_len(plen_q)};
	assign allow_we   = fin_go && (op_q == ipfrl_pkg::OP_WR_ALLOW)
		&& (slot_q < 4'(PREFIX_ENTRIES > 15 ? 15 : PREFIX_ENTRIES) || PREFIX_ENTRIES > 15);
	assign deny_we    = fin_go && (op_q == ipfrl_pkg::OP_WR_DENY)
		&& (slot_q < 4'(PREFIX_ENTRIES > 15 ? 15 : PREFIX_ENTRIES) || PREFIX_ENTRIES > 15);
	assign rate_we    = fin_go && (op_q == ipfrl_pkg::OP_WR_RATE)
		&& (slot_q < 4'(RATE_ENTRIES > 15 ? 15 : RATE_ENTRIES) || RATE_ENTRIES > 15);
	assign rate_wdata = {addr_q, gap_in_q};
	assign stamp_we   = (state_q == ST_DECIDE) && rate_apply && !rate_block;

	ipfrl_ram #(.WIDTH(32), .DEPTH(SOURCE_ENTRIES)) u_tag_ram (
		.clk(clk), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(addr_q),
		.rd_addr(k_q[SAW-1:0]), .rd_data(tag_rd)
	);

	ipfrl_ram #(.WIDTH(ipfrl_pkg::CTR_W), .DEPTH(SOURCE_ENTRIES)) u_ctr_ram (
		.clk(clk), .wr_en(ctr_we), .wr_addr(ctr_waddr), .wr_data(ctr_wdata),
		.rd_addr(src_idx_q), .rd_data(ctr_rd)
	);

	ipfrl_ram #(.WIDTH(ipfrl_pkg::PFX_W), .DEPTH(PREFIX_ENTRIES)) u_allow_ram (
		.clk(clk), .wr_en(allow_we), .wr_addr(PAW'(slot_q)), .wr_data(pfx_wdata),
		.rd_addr(k_q[PAW-1:0]), .rd_data(allow_rd)
	);

	ipfrl_ram #(.WIDTH(ipfrl_pkg::PFX_W), .DEPTH(PREFIX_ENTRIES)) u_deny_ram (
		.clk(clk), .wr_en(deny_we), .wr_addr(PAW'(slot_q)), .wr_data(pfx_wdata),
		.rd_addr(k_q[PAW-1:0]), .rd_data(deny_rd)
	);

	ipfrl_ram #(.WIDTH(ipfrl_pkg::RATE_W), .DEPTH(RATE_ENTRIES)) u_rate_ram (
		.clk(clk), .wr_en(rate_we), .wr_addr(RAW'(slot_q)), .wr_data(rate_wdata),
		.rd_addr(k_q[RAW-1:0]), .rd_data(rate_rd)
	);

	ipfrl_ram #(.WIDTH(64), .DEPTH(RATE_ENTRIES)) u_stamp_ram (
		.clk(clk), .wr_en(stamp_we), .wr_addr(rate_idx_q), .wr_data(now_q),
		.rd_addr(k_q[RAW-1:0]), .rd_data(stamp_rd)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_allow_q <= 1'b0;
			reg_deny_q  <= 1'b0;
			reg_rate_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ipfrl_pkg::CFG_ALLOW_EN: reg_allow_q <= cfg_data;
				ipfrl_pkg::CFG_DENY_EN:  reg_deny_q  <= cfg_data;
				ipfrl_pkg::CFG_RATE_EN:  reg_rate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q        <= ipfrl_pkg::op_t'(op);
			addr_q      <= address;
			bytes_q     <= frame_bytes;
			ipv4_q      <= is_ipv4;
			now_q       <= now_ns;
			slot_q      <= slot;
			plen_q      <= prefix_len;
			gap_in_q    <= interval_ns;
			ent_valid_q <= entry_valid;
		end
	end

	// Sequencer, scan compare and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= '0;
			k_s1           <= '0;
			scan_v_s1      <= 1'b0;
			fill_q         <= '0;
			src_hit_q      <= 1'b0;
			src_idx_q      <= '0;
			allow_hit_q    <= 1'b0;
			deny_hit_q     <= 1'b0;
			rate_hit_q     <= 1'b0;
			rate_seen_q    <= 1'b0;
			rate_idx_q     <= '0;
			rate_gap_q     <= '0;
			rate_last_q    <= '0;
			drop_q         <= 1'b0;
			total_drops_q  <= '0;
			total_passes_q <= '0;
			out_valid      <= 1'b0;
			verdict        <= 1'b0;
			logged         <= 1'b0;
			log_source     <= '0;
			log_bytes      <= '0;
			found          <= 1'b0;
			drop_count     <= '0;
			pass_count     <= '0;
			for (int i = 0; i < PREFIX_ENTRIES; i++) begin
				allow_used_q[i] <= 1'b0;
				deny_used_q[i]  <= 1'b0;
			end
			for (int i = 0; i < RATE_ENTRIES; i++) begin
				rate_used_q[i] <= 1'b0;
				seen_q[i]      <= 1'b0;
			end
		end else begin
			if (out_valid && !out_stall && !fin_go) begin
				out_valid <= 1'b0;
			end

			// Compare stage: RAM data of index k_s1 arrives here.
			if (scan_v_s1) begin
				if ((k_s1 < KW'(SOURCE_ENTRIES - 1) || k_s1 == KW'(SOURCE_ENTRIES - 1))
						&& (FW'(k_s1) < fill_q) && tag_rd == addr_q && !src_hit_q) begin
					src_hit_q <= 1'b1;
					src_idx_q <= k_s1[SAW-1:0];
				end
				if (k_s1 < KW'(PREFIX_ENTRIES - 1) || k_s1 == KW'(PREFIX_ENTRIES - 1)) begin
					if (allow_used_q[k_s1[PAW-1:0]] && (((allow_rd[37:6] ^ addr_q)
							& ipfrl_pkg::len_mask(allow_rd[5:0])) == '0)) begin
						allow_hit_q <= 1'b1;
					end
					if (deny_used_q[k_s1[PAW-1:0]] && (((deny_rd[37:6] ^ addr_q)
							& ipfrl_pkg::len_mask(deny_rd[5:0])) == '0)) begin
						deny_hit_q <= 1'b1;
					end
				end
				// The lowest matching rate entry wins.
				if ((k_s1 < KW'(RATE_ENTRIES - 1) || k_s1 == KW'(RATE_ENTRIES - 1))
						&& rate_used_q[k_s1[RAW-1:0]] && rate_rd[95:64] == addr_q
						&& !rate_hit_q) begin
					rate_hit_q  <= 1'b1;
					rate_idx_q  <= k_s1[RAW-1:0];
					rate_gap_q  <= rate_rd[63:0];
					rate_last_q <= stamp_rd;
					rate_seen_q <= seen_q[k_s1[RAW-1:0]];
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					scan_v_s1 <= 1'b0;
					if (in_valid) begin
						src_hit_q   <= 1'b0;
						allow_hit_q <= 1'b0;
						deny_hit_q  <= 1'b0;
						rate_hit_q  <= 1'b0;
						k_q         <= '0;
						if ((op == ipfrl_pkg::OP_PACKET && is_ipv4)
								|| op == ipfrl_pkg::OP_RD_SRC) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					k_s1      <= k_q;
					scan_v_s1 <= 1'b1;
					if (k_q == KW'(SCAN_LEN - 1)) begin
						state_q <= ST_TAIL;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_TAIL: begin
					scan_v_s1 <= 1'b0;
					state_q   <= ST_DECIDE;
				end
				ST_DECIDE: begin
					drop_q <= pre_drop || (rate_apply && rate_block);
					if (rate_apply && !rate_seen_q) begin
						seen_q[rate_idx_q] <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						verdict    <= 1'b0;
						logged     <= 1'b0;
						log_source <= '0;
						log_bytes  <= '0;
						found      <= 1'b0;
						drop_count <= '0;
						pass_count <= '0;
						state_q    <= ST_IDLE;
						unique case (op_q)
							ipfrl_pkg::OP_PACKET: begin
								if (ipv4_q) begin
									verdict    <= drop_q;
									logged     <= 1'b1;
									log_source <= addr_q;
									log_bytes  <= bytes_q;
									if (claim) begin
										fill_q <= fill_q + 1'b1;
									end
									if (drop_q) begin
										total_drops_q <= total_drops_q + 64'd1;
									end else begin
										total_passes_q <= total_passes_q + 64'd1;
									end
								end
							end
							ipfrl_pkg::OP_WR_ALLOW: begin
								if (allow_we) begin
									allow_used_q[PAW'(slot_q)] <= ent_valid_q;
								end
							end
							ipfrl_pkg::OP_WR_DENY: begin
								if (deny_we) begin
									deny_used_q[PAW'(slot_q)] <= ent_valid_q;
								end
							end
							ipfrl_pkg::OP_WR_RATE: begin
								if (rate_we) begin
									rate_used_q[RAW'(slot_q)] <= ent_valid_q;
									seen_q[RAW'(slot_q)]      <= 1'b0;
								end
							end
							ipfrl_pkg::OP_RD_SRC: begin
								if (src_hit_q) begin
									found      <= 1'b1;
									drop_count <= ctr_rd[127:64];
									pass_count <= ctr_rd[63:0];
								end
							end
							ipfrl_pkg::OP_RD_TOT: begin
								drop_count <= total_drops_q;
								pass_count <= total_passes_q;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`IPFRL_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FW'(SOURCE_ENTRIES))
	`IPFRL_ASSERT_NEXT(a_fill_step, clk, arst_n, 1'b1,
		fill_q == $past(fill_q) || fill_q == $past(fill_q) + 1'b1)
	`IPFRL_ASSERT_IMPL(a_hit_in_fill, clk, arst_n, src_hit_q, FW'(src_idx_q) < fill_q)
	`IPFRL_ASSERT_NEXT(a_packet_logged, clk, arst_n,
		fin_go && op_q == ipfrl_pkg::OP_PACKET && ipv4_q, out_valid && logged)

endmodule

// ----- design/ipfrl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfrl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ipfrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
